[rtl/cstr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cstr_pkg: shared types and constants of the cursor shape decoder
// Item layouts, register indexes, shape kinds, status codes and the command
// word that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package cstr_pkg;

  // Sizing
  localparam int STORE_BYTES_DEF = 16384;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int NUM_BANKS       = 4;
  localparam int ADDR_W          = 21;  // covers (2 * 511) * 2047 + 31
  localparam int PROD_W          = 20;  // 9 x 11 bit products

  // Field widths
  localparam int KIND_W     = 2;
  localparam int WIDTH_W    = 9;
  localparam int HEIGHT_W   = 10;
  localparam int PITCH_W    = 11;
  localparam int COUNT_W    = 15;
  localparam int BADDR_W    = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  // Pixel constants
  localparam logic [7:0] MSB_MASK = 8'h80;
  localparam logic [7:0] FULL     = 8'hFF;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KIND   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 3'd4;

  // Shape kinds
  localparam logic [KIND_W-1:0] KIND_MONO   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_COLOR  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MASKED = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

  // Item modes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_PIXEL = 1'b1;

  // Result status
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD     = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;

  typedef struct packed {
    logic               mode;
    logic [BADDR_W-1:0] byte_addr;
    logic [7:0]         byte_value;
    logic [7:0]         pixel_x;
    logic [8:0]         pixel_y;
  } in_item_t;

  typedef struct packed {
    logic [7:0]          red;
    logic [7:0]          green;
    logic [7:0]          blue;
    logic [7:0]          alpha;
    logic [WIDTH_W-1:0]  image_width;
    logic [HEIGHT_W-1:0] image_height;
    logic [1:0]          status;
  } out_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [WIDTH_W-1:0]  width;
    logic [HEIGHT_W-1:0] height;
    logic [PITCH_W-1:0]  pitch;
    logic [COUNT_W-1:0]  count;
  } cfg_t;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_MONO  = 2'd1,
    OP_COLOR = 2'd2,
    OP_FLAG  = 2'd3
  } op_t;

  // Classified item handed to the back end
  typedef struct packed {
    op_t                 op;
    logic [ADDR_W-1:0]   addr_a;   // load address, AND byte or pixel base
    logic [ADDR_W-1:0]   addr_b;   // XOR byte
    logic                ok_a;     // bytes of addr_a inside the valid count
    logic                ok_b;
    logic [2:0]          bit_sel;
    logic                masked;
    logic [7:0]          wdata;
    logic [WIDTH_W-1:0]  img_w;
    logic [HEIGHT_W-1:0] img_h;
    logic [1:0]          status;
  } cmd_t;

endpackage

[rtl/cstr_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cstr_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module cstr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

[rtl/cstr_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cstr_queue: command queue between front end and back end
// Small register FIFO of classified items.
// ----------------------------------------------------------------------------
module cstr_queue #(
  parameter int DEPTH = cstr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cstr_pkg::cmd_t push_cmd,
  input  logic           pop,
  output cstr_pkg::cmd_t head_cmd,
  output logic           full,
  output logic           empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cstr_pkg::cmd_t    mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign head_cmd = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue fill count beyond depth");
`endif

endmodule

[rtl/cstr_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cstr_front: item intake and classification
// Registers each item with its status, image size and row products, then works
// out store addresses and count checks and queues the resulting command.
// ----------------------------------------------------------------------------
module cstr_front #(
  parameter int STORE_BYTES = cstr_pkg::STORE_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  cstr_pkg::in_item_t item,
  input  cstr_pkg::cfg_t     cfg,
  input  logic               q_full,
  output logic               q_push,
  output cstr_pkg::cmd_t     q_cmd
);

  localparam int AW = cstr_pkg::ADDR_W;
  localparam int PW = cstr_pkg::PROD_W;

  logic                         accept;
  logic                         bad_c, outside_c;
  logic [cstr_pkg::HEIGHT_W-1:0] img_h_c;
  logic [8:0]                   half_h_c;

  logic                          a_vld_r, a_vld_nxt;
  cstr_pkg::in_item_t            a_item_r;
  logic [1:0]                    a_status_r;
  logic [cstr_pkg::WIDTH_W-1:0]  a_img_w_r;
  logic [cstr_pkg::HEIGHT_W-1:0] a_img_h_r;
  logic [PW-1:0]                 a_prod_r;
  logic [PW-1:0]                 a_plane_r;

  logic [AW-1:0] count_c, and_addr_c, xor_addr_c, base_c;
  logic          drop_c;

  assign accept = start && !busy;
  assign busy   = a_vld_r && q_full;

  // Setup and bounds checks on the incoming pixel request
  always_comb begin
    half_h_c  = cfg.height[cstr_pkg::HEIGHT_W-1:1];
    img_h_c   = (cfg.kind == cstr_pkg::KIND_MONO) ? {1'b0, half_h_c} : cfg.height;
    bad_c     = (cfg.count == '0) || (cfg.width == '0) || (cfg.height == '0) ||
                (cfg.pitch == '0) || (cfg.kind == cstr_pkg::KIND_NONE);
    outside_c = ({1'b0, item.pixel_x} >= cfg.width) ||
                ({1'b0, item.pixel_y} >= img_h_c);
  end

  assign a_vld_nxt = accept ? 1'b1 : (a_vld_r && q_full);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= a_vld_nxt;
    end
  end

  // Stage A payload: item, status and row products
  always_ff @(posedge clk) begin
    if (accept) begin
      a_item_r  <= item;
      a_prod_r  <= PW'(item.pixel_y) * PW'(cfg.pitch);
      a_plane_r <= PW'(half_h_c) * PW'(cfg.pitch);
      if (bad_c) begin
        a_status_r <= cstr_pkg::ST_BAD;
        a_img_w_r  <= '0;
        a_img_h_r  <= '0;
      end else begin
        a_status_r <= outside_c ? cstr_pkg::ST_OUTSIDE : cstr_pkg::ST_OK;
        a_img_w_r  <= cfg.width;
        a_img_h_r  <= img_h_c;
      end
    end
  end

  // Store addresses and valid-count checks
  always_comb begin
    count_c    = (AW'(cfg.count) > AW'(STORE_BYTES)) ? AW'(STORE_BYTES) : AW'(cfg.count);
    and_addr_c = AW'(a_prod_r) + AW'(a_item_r.pixel_x[7:3]);
    xor_addr_c = and_addr_c + AW'(a_plane_r);
    base_c     = AW'(a_prod_r) + AW'({a_item_r.pixel_x, 2'b00});
    drop_c     = (a_item_r.mode == cstr_pkg::MODE_LOAD) &&
                 (AW'(a_item_r.byte_addr) >= AW'(STORE_BYTES));
  end

  // Command build
  always_comb begin
    q_cmd         = '0;
    q_cmd.addr_b  = xor_addr_c;
    q_cmd.ok_b    = (xor_addr_c < count_c);
    q_cmd.bit_sel = a_item_r.pixel_x[2:0];
    q_cmd.masked  = (cfg.kind == cstr_pkg::KIND_MASKED);
    q_cmd.wdata   = a_item_r.byte_value;
    q_cmd.img_w   = a_img_w_r;
    q_cmd.img_h   = a_img_h_r;
    q_cmd.status  = a_status_r;
    if (a_item_r.mode == cstr_pkg::MODE_LOAD) begin
      q_cmd.op     = cstr_pkg::OP_LOAD;
      q_cmd.addr_a = AW'(a_item_r.byte_addr);
      q_cmd.ok_a   = 1'b1;
    end else if (a_status_r != cstr_pkg::ST_OK) begin
      q_cmd.op     = cstr_pkg::OP_FLAG;
      q_cmd.addr_a = base_c;
      q_cmd.ok_a   = 1'b0;
    end else if (cfg.kind == cstr_pkg::KIND_MONO) begin
      q_cmd.op     = cstr_pkg::OP_MONO;
      q_cmd.addr_a = and_addr_c;
      q_cmd.ok_a   = (and_addr_c < count_c);
    end else begin
      q_cmd.op     = cstr_pkg::OP_COLOR;
      q_cmd.addr_a = base_c;
      q_cmd.ok_a   = ((base_c + AW'(3)) < count_c);
    end
  end

  // Loads beyond the store leave stage A without a command
  assign q_push = a_vld_r && !q_full && !drop_c;

endmodule

[rtl/cstr_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cstr_back: store access and pixel formatting
// Four byte-interleaved banks hold the shape; a colour pixel reads one byte
// from each, a monochrome pixel reads its AND and XOR bytes in two passes.
// ----------------------------------------------------------------------------
module cstr_back #(
  parameter int BANK_DEPTH = cstr_pkg::STORE_BYTES_DEF / cstr_pkg::NUM_BANKS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  cstr_pkg::cmd_t      q_cmd,
  output logic                q_pop,
  output logic                out_strobe,
  output cstr_pkg::out_item_t out_data
);

  localparam int BW = $clog2(BANK_DEPTH);
  localparam int NB = cstr_pkg::NUM_BANKS;

  logic          have;
  logic          phase_r, phase_nxt;
  logic [1:0]    sel_lo;
  logic [BW-1:0] word_a, word_b;
  logic [7:0]    rdata [NB];

  logic                          r_vld_r, r_vld_nxt;
  cstr_pkg::op_t                 r_op_r;
  logic                          r_phase_r;
  logic                          r_ok_r;
  logic [1:0]                    r_lo_r;
  logic [2:0]                    r_bit_r;
  logic                          r_masked_r;
  logic [cstr_pkg::WIDTH_W-1:0]  r_img_w_r;
  logic [cstr_pkg::HEIGHT_W-1:0] r_img_h_r;
  logic [1:0]                    r_status_r;
  logic                          and_bit_r;

  logic                out_vld_r, out_vld_nxt;
  cstr_pkg::out_item_t out_data_r, out_data_nxt;
  logic [7:0]          mono_byte, byte_mask, alpha_raw;
  logic                plane_bit;

  // Issue: monochrome holds the head for a second pass
  assign have      = !q_empty;
  assign q_pop     = have && ((q_cmd.op != cstr_pkg::OP_MONO) || phase_r);
  assign phase_nxt = have && (q_cmd.op == cstr_pkg::OP_MONO) && !phase_r;
  assign word_a    = q_cmd.addr_a[BW+1:2];
  assign word_b    = q_cmd.addr_b[BW+1:2];
  assign sel_lo    = phase_r ? q_cmd.addr_b[1:0] : q_cmd.addr_a[1:0];
  assign r_vld_nxt = have && (q_cmd.op != cstr_pkg::OP_LOAD);

  // Shape store banks, byte address bits [1:0] pick the bank
  for (genvar b = 0; b < NB; b++) begin : g_bank
    logic          we;
    logic [BW-1:0] raddr;

    assign we = have && (q_cmd.op == cstr_pkg::OP_LOAD) && (q_cmd.addr_a[1:0] == 2'(b));

    always_comb begin
      unique case (q_cmd.op)
        cstr_pkg::OP_COLOR: raddr = word_a + BW'(2'(b) < q_cmd.addr_a[1:0]);
        cstr_pkg::OP_MONO:  raddr = phase_r ? word_b : word_a;
        cstr_pkg::OP_LOAD,
        cstr_pkg::OP_FLAG:  raddr = word_a;
      endcase
    end

    cstr_ram #(
      .WIDTH (8),
      .DEPTH (BANK_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (word_a),
      .wdata (q_cmd.wdata),
      .raddr (raddr),
      .rdata (rdata[b])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      r_vld_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      r_vld_r <= r_vld_nxt;
    end
  end

  // Read stage payload, aligned with the RAM output
  always_ff @(posedge clk) begin
    r_op_r     <= q_cmd.op;
    r_phase_r  <= phase_r;
    r_ok_r     <= phase_r ? q_cmd.ok_b : q_cmd.ok_a;
    r_lo_r     <= sel_lo;
    r_bit_r    <= q_cmd.bit_sel;
    r_masked_r <= q_cmd.masked;
    r_img_w_r  <= q_cmd.img_w;
    r_img_h_r  <= q_cmd.img_h;
    r_status_r <= q_cmd.status;
  end

  // Pixel formatting
  always_comb begin
    mono_byte    = rdata[r_lo_r];
    byte_mask    = cstr_pkg::MSB_MASK >> r_bit_r;
    plane_bit    = r_ok_r && ((mono_byte & byte_mask) != '0);
    alpha_raw    = rdata[r_lo_r + 2'd3];
    out_data_nxt              = '0;
    out_data_nxt.image_width  = r_img_w_r;
    out_data_nxt.image_height = r_img_h_r;
    out_data_nxt.status       = r_status_r;
    out_vld_nxt               = r_vld_r;
    unique case (r_op_r)
      cstr_pkg::OP_MONO: begin
        out_vld_nxt = r_vld_r && r_phase_r;
        if (!and_bit_r) begin
          out_data_nxt.red   = plane_bit ? cstr_pkg::FULL : 8'h00;
          out_data_nxt.green = plane_bit ? cstr_pkg::FULL : 8'h00;
          out_data_nxt.blue  = plane_bit ? cstr_pkg::FULL : 8'h00;
          out_data_nxt.alpha = cstr_pkg::FULL;
        end else if (plane_bit) begin
          out_data_nxt.red   = cstr_pkg::FULL;
          out_data_nxt.green = cstr_pkg::FULL;
          out_data_nxt.blue  = cstr_pkg::FULL;
          out_data_nxt.alpha = cstr_pkg::FULL;
        end
      end
      cstr_pkg::OP_COLOR: begin
        if (r_ok_r) begin
          out_data_nxt.blue  = rdata[r_lo_r];
          out_data_nxt.green = rdata[r_lo_r + 2'd1];
          out_data_nxt.red   = rdata[r_lo_r + 2'd2];
          if (r_masked_r) begin
            out_data_nxt.alpha = (alpha_raw != '0) ? 8'h00 : cstr_pkg::FULL;
          end else begin
            out_data_nxt.alpha = alpha_raw;
          end
        end
      end
      cstr_pkg::OP_LOAD,
      cstr_pkg::OP_FLAG: begin
      end
    endcase
  end

  // AND plane bit waits for the XOR pass
  always_ff @(posedge clk) begin
    if (r_vld_r && (r_op_r == cstr_pkg::OP_MONO) && !r_phase_r) begin
      and_bit_r <= plane_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_strobe = out_vld_r;
  assign out_data   = out_data_r;

`ifndef SYNTHESIS
  a_flag_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (out_data_r.status != cstr_pkg::ST_OK)) |->
    ({out_data_r.red, out_data_r.green, out_data_r.blue, out_data_r.alpha} == '0))
    else $error("flagged result carries pixel data");
  a_bad_no_size: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (out_data_r.status == cstr_pkg::ST_BAD)) |->
    ((out_data_r.image_width == '0) && (out_data_r.image_height == '0)))
    else $error("bad setup result carries an image size");
  a_xor_after_and: assert property (@(posedge clk) disable iff (!rst_n)
    (r_vld_r && (r_op_r == cstr_pkg::OP_MONO) && r_phase_r) |->
    $past(r_vld_r && (r_op_r == cstr_pkg::OP_MONO) && !r_phase_r))
    else $error("XOR pass without preceding AND pass");
`endif

endmodule

[rtl/cursor_shape_to_rgba.sv]
`timescale 1ns / 1ps
// Results pass stage A, the command queue, a bank read stage and the output register.
// Throughput: load, colour and flagged items 1 per cycle while busy is low; monochrome
// pixels hold the queue head for two bank reads, of the AND and XOR planes.
// Results cannot be stalled; busy rises only when the command queue backs up.
// Reset (synchronous, rst_n low) clears control state and the configuration
// registers; shape store contents are not cleared.
// ----------------------------------------------------------------------------
// cursor_shape_to_rgba: pointer shape to RGBA pixel decoder
// Config registers, front end classifier, command queue and back end store
// access with pixel formatting.
// ----------------------------------------------------------------------------
module cursor_shape_to_rgba #(
  parameter int STORE_BYTES = cstr_pkg::STORE_BYTES_DEF,
  parameter int QUEUE_DEPTH = cstr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  cstr_pkg::in_item_t                 in_data,
  output logic                               out_strobe,
  output cstr_pkg::out_item_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cstr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cstr_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int BANK_DEPTH = (STORE_BYTES + cstr_pkg::NUM_BANKS - 1) / cstr_pkg::NUM_BANKS;

  cstr_pkg::cfg_t cfg_r, cfg_nxt;
  logic           q_push, q_pop, q_full, q_empty;
  cstr_pkg::cmd_t push_cmd, head_cmd;

  assign cfg_ready = 1'b1;

  // Configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        cstr_pkg::REG_KIND:   cfg_nxt.kind   = cfg_data[cstr_pkg::KIND_W-1:0];
        cstr_pkg::REG_WIDTH:  cfg_nxt.width  = cfg_data[cstr_pkg::WIDTH_W-1:0];
        cstr_pkg::REG_HEIGHT: cfg_nxt.height = cfg_data[cstr_pkg::HEIGHT_W-1:0];
        cstr_pkg::REG_PITCH:  cfg_nxt.pitch  = cfg_data[cstr_pkg::PITCH_W-1:0];
        cstr_pkg::REG_COUNT:  cfg_nxt.count  = cfg_data[cstr_pkg::COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  cstr_front #(
    .STORE_BYTES (STORE_BYTES)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .item   (in_data),
    .cfg    (cfg_r),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (push_cmd)
  );

  cstr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  cstr_back #(
    .BANK_DEPTH (BANK_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_cmd      (head_cmd),
    .q_pop      (q_pop),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule

[tb/cursor_shape_to_rgba_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_shape_to_rgba_tb: self-checking bench for the pointer shape decoder
// Loads shape bytes, changes the shape setup between quiet phases, and asks
// for pixels in monochrome, colour, masked colour and unsupported shapes.
// A scoreboard decodes every pixel request from its own shadow copy of the
// shape store and checks each strobed result field by field, in order.
// ----------------------------------------------------------------------------
module cursor_shape_to_rgba_tb;

  localparam int STORE_SIZE     = cstr_pkg::STORE_BYTES_DEF;
  localparam int ITEM_TARGET    = 700;
  localparam int SETTLE_CYCLES  = 24;    // drain time for the queue and back end, with margin
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake of any kind

  // Shadow decoder: shape store copy, setup registers and expected pixels
  class rgba_scoreboard;
    logic [7:0]          store [STORE_SIZE];
    bit                  written [STORE_SIZE];
    logic [1:0]          kind;
    int unsigned         shape_w, shape_h, pitch, byte_count;
    int unsigned         touched[$];          // store bytes read by the last decode
    cstr_pkg::out_item_t pending_pixels[$];
    int unsigned         fails, pixels, results;

    function new();
      kind = cstr_pkg::KIND_MONO;
      shape_w = 0;
      shape_h = 0;
      pitch = 0;
      byte_count = 0;
      fails = 0;
      pixels = 0;
      results = 0;
    endfunction

    function void note_config(logic [cstr_pkg::CFG_IDX_W-1:0] idx,
                              logic [cstr_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        cstr_pkg::REG_KIND:   kind = val[cstr_pkg::KIND_W-1:0];
        cstr_pkg::REG_WIDTH:  shape_w = 32'(val[cstr_pkg::WIDTH_W-1:0]);
        cstr_pkg::REG_HEIGHT: shape_h = 32'(val[cstr_pkg::HEIGHT_W-1:0]);
        cstr_pkg::REG_PITCH:  pitch = 32'(val[cstr_pkg::PITCH_W-1:0]);
        cstr_pkg::REG_COUNT:  byte_count = 32'(val[cstr_pkg::COUNT_W-1:0]);
        default: ;
      endcase
    endfunction

    // Bytes at or past the valid count read as zero
    function logic [7:0] peek(int unsigned a, int unsigned cnt);
      if (a >= cnt) return 8'h00;
      touched = {touched, a};
      return store[a];
    endfunction

    function cstr_pkg::out_item_t decode_pixel(cstr_pkg::in_item_t it);
      cstr_pkg::out_item_t res;
      int unsigned         x, y, rows, cnt, base;
      logic [7:0]          msk, and_bit, xor_bit;
      res = '0;
      touched = {};
      x = 32'(it.pixel_x);
      y = 32'(it.pixel_y);
      cnt = (byte_count > STORE_SIZE) ? STORE_SIZE : byte_count;
      if (byte_count == 0 || shape_w == 0 || shape_h == 0 || pitch == 0 ||
          kind == cstr_pkg::KIND_NONE) begin
        res.status = cstr_pkg::ST_BAD;
      end else begin
        rows = (kind == cstr_pkg::KIND_MONO) ? shape_h / 2 : shape_h;
        res.image_width = 9'(shape_w);
        res.image_height = 10'(rows);
        if (x >= shape_w || y >= rows) begin
          res.status = cstr_pkg::ST_OUTSIDE;
        end else if (kind == cstr_pkg::KIND_MONO) begin
          // AND plane on top, XOR plane below it, MSB first
          msk = cstr_pkg::MSB_MASK >> (x % 8);
          and_bit = peek(y * pitch + x / 8, cnt) & msk;
          xor_bit = peek((rows + y) * pitch + x / 8, cnt) & msk;
          if (and_bit == 8'h00) begin
            res.red = (xor_bit != 8'h00) ? cstr_pkg::FULL : 8'h00;
            res.green = res.red;
            res.blue = res.red;
            res.alpha = cstr_pkg::FULL;
          end else if (xor_bit != 8'h00) begin
            res.red = cstr_pkg::FULL;
            res.green = cstr_pkg::FULL;
            res.blue = cstr_pkg::FULL;
            res.alpha = cstr_pkg::FULL;
          end
        end else begin
          // BGRA in the store, whole pixel must sit below the count
          base = y * pitch + x * 4;
          if (base + 3 < cnt) begin
            res.blue = peek(base, cnt);
            res.green = peek(base + 1, cnt);
            res.red = peek(base + 2, cnt);
            res.alpha = peek(base + 3, cnt);
            if (kind == cstr_pkg::KIND_MASKED) begin
              res.alpha = (res.alpha != 8'h00) ? 8'h00 : cstr_pkg::FULL;
            end
          end
        end
      end
      return res;
    endfunction

    // Store bytes a pixel request would read that were never loaded
    function void unloaded_bytes(cstr_pkg::in_item_t it, ref int unsigned addrs[$]);
      cstr_pkg::out_item_t unused;
      addrs = {};
      unused = decode_pixel(it);
      foreach (touched[i]) if (!written[touched[i]]) addrs = {addrs, touched[i]};
    endfunction

    function void note_item(cstr_pkg::in_item_t it);
      if (it.mode == cstr_pkg::MODE_LOAD) begin
        if (it.byte_addr < STORE_SIZE) begin
          store[it.byte_addr] = it.byte_value;
          written[it.byte_addr] = 1'b1;
        end
      end else begin
        pending_pixels = {pending_pixels, decode_pixel(it)};
        pixels++;
      end
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        fails++;
      end
    endfunction

    function void check_result(cstr_pkg::out_item_t got);
      cstr_pkg::out_item_t want;
      if (pending_pixels.size() == 0) begin
        $error("result strobed with no pixel request outstanding");
        fails++;
        return;
      end
      want = pending_pixels.pop_front();
      results++;
      cmp_field("red", 32'(want.red), 32'(got.red));
      cmp_field("green", 32'(want.green), 32'(got.green));
      cmp_field("blue", 32'(want.blue), 32'(got.blue));
      cmp_field("alpha", 32'(want.alpha), 32'(got.alpha));
      cmp_field("image_width", 32'(want.image_width), 32'(got.image_width));
      cmp_field("image_height", 32'(want.image_height), 32'(got.image_height));
      cmp_field("status", 32'(want.status), 32'(got.status));
    endfunction

    function void finish_check();
      if (pending_pixels.size() != 0) begin
        $error("%0d pixel results never arrived", pending_pixels.size());
        fails++;
      end
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            start;
  logic                            busy;
  cstr_pkg::in_item_t              in_data;
  logic                            out_strobe;
  cstr_pkg::out_item_t             out_data;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [cstr_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [cstr_pkg::CFG_DATA_W-1:0] cfg_data;

  rgba_scoreboard sb;
  int unsigned    gap_pct;
  int unsigned    items;
  int unsigned    setups;
  int unsigned    quiet_cycles;

  cursor_shape_to_rgba i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 100 MHz clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_strobe === 1'b1) sb.check_result(out_data);
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("cursor_shape_to_rgba: mismatch");
      $finish;
    end
  end

  function automatic cstr_pkg::in_item_t random_item();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[$bits(cstr_pkg::in_item_t)-1:0];
  endfunction

  // Random gap at the falling edge, then hold start until the block takes the item
  task automatic send_item(cstr_pkg::in_item_t it);
    @(negedge clk);
    while (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_item(it);
    items++;
  endtask

  task automatic load_byte(int unsigned addr, logic [7:0] val);
    cstr_pkg::in_item_t it;
    it = random_item();
    it.mode = cstr_pkg::MODE_LOAD;
    it.byte_addr = 14'(addr);
    it.byte_value = val;
    send_item(it);
  endtask

  // Any store byte the pixel would read gets loaded first
  task automatic send_pixel(cstr_pkg::in_item_t it);
    int unsigned addrs[$];
    sb.unloaded_bytes(it, addrs);
    foreach (addrs[i]) load_byte(addrs[i], ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
    send_item(it);
  endtask

  task automatic ask_pixel(int unsigned x, int unsigned y);
    cstr_pkg::in_item_t it;
    it = random_item();
    it.mode = cstr_pkg::MODE_PIXEL;
    it.pixel_x = 8'(x);
    it.pixel_y = 9'(y);
    send_pixel(it);
  endtask

  // Stop sending, wait for every pixel result, then let the pipe empty
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [cstr_pkg::CFG_IDX_W-1:0] idx,
                           logic [cstr_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.note_config(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_shape(int unsigned k, int unsigned w, int unsigned h,
                           int unsigned p, int unsigned c);
    settle();
    write_reg(cstr_pkg::REG_KIND, 15'(k));
    write_reg(cstr_pkg::REG_WIDTH, 15'(w));
    write_reg(cstr_pkg::REG_HEIGHT, 15'(h));
    write_reg(cstr_pkg::REG_PITCH, 15'(p));
    write_reg(cstr_pkg::REG_COUNT, 15'(c));
    setups++;
  endtask

  // Occasionally set bits above the register width
  function automatic int unsigned dirty(int unsigned v, int bits);
    int unsigned m;
    m = (32'd1 << bits) - 32'd1;
    if ($urandom_range(0, 7) == 0) return (v & m) | ($urandom & ~m & 32'h7FFF);
    return v & m;
  endfunction

  // Mostly consistent small layouts, some huge, some broken
  task automatic random_shape();
    logic [1:0]  k;
    int unsigned w, rows, h, p, c, total, sel;
    sel = $urandom_range(0, 19);
    k = (sel < 7) ? cstr_pkg::KIND_MONO : (sel < 12) ? cstr_pkg::KIND_COLOR :
        (sel < 18) ? cstr_pkg::KIND_MASKED : cstr_pkg::KIND_NONE;
    w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 24);
    rows = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 16);
    h = (k == cstr_pkg::KIND_MONO) ? 2 * rows + $urandom_range(0, 1) : rows;
    p = (k == cstr_pkg::KIND_MONO) ? (w + 7) / 8 : w * 4;
    p = p + $urandom_range(0, 3);
    if ($urandom_range(0, 9) == 0) p = $urandom_range(0, 2047);
    if (p > 2047) p = 2047;
    total = p * h;
    sel = $urandom_range(0, 19);
    if (sel < 12) c = total;
    else if (sel < 17) c = total - $urandom_range(0, total / 4);
    else c = $urandom_range(0, 32767);
    if (c > 32767) c = 32767;
    case ($urandom_range(0, 15))
      0: w = 0;
      1: h = 0;
      2: p = 0;
      3: c = 0;
      default: ;
    endcase
    set_shape(dirty(32'(k), cstr_pkg::KIND_W), dirty(w, cstr_pkg::WIDTH_W),
              dirty(h, cstr_pkg::HEIGHT_W), dirty(p, cstr_pkg::PITCH_W), c);
  endtask

  initial begin
    cstr_pkg::in_item_t it;
    int unsigned        rows, cols, phase, burst;
    sb = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    gap_pct = 0;
    items = 0;
    setups = 0;
    quiet_cycles = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: all registers zero after reset
    ask_pixel(0, 0);

    // Monochrome 16x4: the four AND/XOR combinations, then both edges
    set_shape(32'(cstr_pkg::KIND_MONO), 16, 8, 2, 16);
    load_byte(0, 8'h33);
    load_byte(8, 8'h55);
    ask_pixel(0, 0);
    ask_pixel(1, 0);
    ask_pixel(2, 0);
    ask_pixel(3, 0);
    ask_pixel(16, 0);
    ask_pixel(0, 4);

    // Colour: one full pixel, one whose alpha byte lies past the count
    set_shape(32'(cstr_pkg::KIND_COLOR), 4, 2, 16, 30);
    ask_pixel(0, 0);
    ask_pixel(3, 1);

    // Masked colour: zero mask opaque, set mask transparent
    set_shape(32'(cstr_pkg::KIND_MASKED), 2, 1, 8, 8);
    load_byte(3, 8'h00);
    load_byte(7, 8'h80);
    ask_pixel(0, 0);
    ask_pixel(1, 0);

    // Unsupported kind
    set_shape(32'(cstr_pkg::KIND_NONE), 1, 1, 1, 1);
    ask_pixel(0, 0);

    // Extremes: monochrome height 1 leaves no rows, count above store size
    set_shape(32'(cstr_pkg::KIND_MONO), 511, 1, 2047, 32767);
    load_byte(STORE_SIZE - 1, 8'hFF);
    ask_pixel(255, 511);

    // Random phases, each with its own shape and sender gap rate
    phase = 0;
    while (items < ITEM_TARGET) begin
      random_shape();
      case (phase % 3)
        0: gap_pct = 0;
        1: gap_pct = 69;
        default: gap_pct = 8;
      endcase
      phase++;
      rows = (sb.kind == cstr_pkg::KIND_MONO) ? sb.shape_h / 2 : sb.shape_h;
      if (rows > 512) rows = 512;
      cols = (sb.shape_w > 256) ? 256 : sb.shape_w;
      burst = $urandom_range(20, 45);
      repeat (burst) begin
        if (items < ITEM_TARGET) begin
          it = random_item();
          if ($urandom_range(0, 7) == 0) begin
            it.mode = cstr_pkg::MODE_LOAD;
            send_item(it);
          end else begin
            it.mode = cstr_pkg::MODE_PIXEL;
            if ($urandom_range(0, 4) != 0 && cols != 0 && rows != 0) begin
              it.pixel_x = 8'($urandom_range(0, cols - 1));
              it.pixel_y = 9'($urandom_range(0, rows - 1));
            end
            send_pixel(it);
          end
          // Now and then let everything drain mid-phase
          if ($urandom_range(0, 49) == 0) settle();
        end
      end
    end

    settle();
    sb.finish_check();
    $display("run covered %0d items over %0d shape setups", items, setups);
    $display("%0d pixel requests, %0d results checked, %0d field errors",
             sb.pixels, sb.results, sb.fails);
    if (sb.fails == 0) $display("cursor_shape_to_rgba: match");
    else $display("cursor_shape_to_rgba: mismatch");
    $finish;
  end

endmodule
